[hdl/swat_pkg.sv]
`default_nettype none

package swat_pkg;

  localparam int unsigned SEQ_W            = 31;
  localparam int unsigned STATUS_W         = 3;
  localparam int unsigned CNT_OUT_W        = 5;
  localparam int unsigned TOTAL_W          = 32;
  localparam int unsigned WINDOW_DEPTH_DEF = 16;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_OUTSIDE  = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_MISMATCH = 3'd4
  } swat_status_e;

  typedef enum logic {
    OP_SEND = 1'b0,
    OP_ACK  = 1'b1
  } swat_op_e;

endpackage

`default_nettype wire

[hdl/swat_ram.sv]
`default_nettype none

module swat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/sliding_window_ack_tracker_core.sv]
// Sender-side go-back-N window tracker.
//
// Input channel (in_valid_i/in_ready_o): operation_i selects a send (store
// seq_value_i at the window tail) or a cumulative acknowledgement of
// seq_value_i. Output channel (out_valid_o/out_ready_i): one result item per
// input item with status, slots released, slots held, next expected sequence
// and the saturating total of released slots.
//
// Timing: an accepted item has its result registered once the output register
// is free; a new item is taken only after the previous result is registered.
// Each item passes through the registered read of the sequence memory and then
// compare and pointer update. Sends write the memory in the same update cycle.
//
// A stalled receiver holds the result in the output register; one further
// item may be accepted and then waits in its update cycle until the output
// register frees up.
//
// Reset empties the window, sets the expected sequence to zero and clears the
// release total. A cfg_we_i write empties the window and loads the expected
// sequence; the release total is kept. Write it only while idle.
`default_nettype none

module sliding_window_ack_tracker_core
  import swat_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [SEQ_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 operation_i,
  input  wire logic [SEQ_W-1:0]     seq_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic [CNT_OUT_W-1:0]      released_now_o,
  output logic [CNT_OUT_W-1:0]      in_flight_o,
  output logic [SEQ_W-1:0]          oldest_seq_o,
  output logic [TOTAL_W-1:0]        released_total_o
);

  localparam int unsigned IW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
    return (p == IW'(WINDOW_DEPTH - 1)) ? '0 : p + IW'(1);
  endfunction

  state_e             state_q, state_d;
  logic [IW-1:0]      head_q, head_d;
  logic [IW-1:0]      tail_q, tail_d;
  logic [CW-1:0]      held_q, held_d;
  logic [SEQ_W-1:0]   expected_q, expected_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  logic               op_q;
  logic [SEQ_W-1:0]   seq_q;
  logic [IW-1:0]      off_q;
  logic               in_range_q;

  logic               out_valid_q;
  swat_status_e       status_q, status_d;
  logic [CNT_OUT_W-1:0] rel_q, rel_d;
  logic [CNT_OUT_W-1:0] flight_q, flight_d;

  logic               in_fire, out_free, exec_fire;
  logic [SEQ_W-1:0]   off_full;
  logic [IW:0]        idx_sum;
  logic [IW-1:0]      idx;
  logic [SEQ_W-1:0]   rdata;
  logic               ram_we;
  logic [CW-1:0]      rel_n;
  logic [TOTAL_W:0]   total_sum;
  logic [31:0]        rel_wide, held_wide;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign exec_fire  = (state_q == S_EXEC) & out_free;

  assign off_full = seq_value_i - expected_q;
  assign idx_sum  = {1'b0, head_q} + {1'b0, off_full[IW-1:0]};
  assign idx      = (idx_sum >= (IW+1)'(WINDOW_DEPTH))
                  ? IW'(idx_sum - (IW+1)'(WINDOW_DEPTH)) : idx_sum[IW-1:0];

  assign rel_n     = CW'(off_q) + CW'(1);
  assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(rel_n);

  swat_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (seq_q),
    .re_i    (in_fire),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    held_d     = held_q;
    expected_d = expected_q;
    total_d    = total_q;
    status_d   = STAT_OK;
    rel_d      = '0;
    ram_we     = 1'b0;
    rel_wide   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d = S_IDLE;
          if (op_q == OP_SEND) begin
            if (held_q == CW'(WINDOW_DEPTH)) begin
              status_d = STAT_FULL;
            end else begin
              ram_we = 1'b1;
              held_d = held_q + CW'(1);
              tail_d = ring_next(tail_q);
            end
          end else if (!in_range_q) begin
            status_d = STAT_OUTSIDE;
          end else if (CW'(off_q) >= held_q) begin
            status_d = STAT_EMPTY;
          end else if (rdata != seq_q) begin
            status_d = STAT_MISMATCH;
          end else begin
            rel_wide   = 32'(rel_n);
            rel_d      = rel_wide[CNT_OUT_W-1:0];
            held_d     = held_q - rel_n;
            head_d     = ring_next(IW'(({1'b0, head_q} + {1'b0, off_q}) >=
                                       (IW+1)'(WINDOW_DEPTH)
                                       ? ({1'b0, head_q} + {1'b0, off_q})
                                         - (IW+1)'(WINDOW_DEPTH)
                                       : ({1'b0, head_q} + {1'b0, off_q})));
            expected_d = expected_q + SEQ_W'(rel_n);
            total_d    = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      head_d     = '0;
      tail_d     = '0;
      held_d     = '0;
      expected_d = cfg_wdata_i;
    end

    held_wide = 32'(held_d);
    flight_d  = held_wide[CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      held_q      <= '0;
      expected_q  <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      held_q     <= held_d;
      expected_q <= expected_d;
      total_q    <= total_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= operation_i;
      seq_q      <= seq_value_i;
      off_q      <= off_full[IW-1:0];
      in_range_q <= (off_full < SEQ_W'(WINDOW_DEPTH));
    end
    if (exec_fire) begin
      status_q <= status_d;
      rel_q    <= rel_d;
      flight_q <= flight_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign released_now_o   = rel_q;
  assign in_flight_o      = flight_q;
  assign oldest_seq_o     = expected_q;
  assign released_total_o = total_q;

endmodule

`default_nettype wire

[hdl/swat_checker.sv]
`default_nettype none

module swat_checker
  import swat_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [STATUS_W-1:0]  status_o,
  input wire logic [CNT_OUT_W-1:0] released_now_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
                                    && $stable(released_now_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= STAT_MISMATCH)
    else $error("undefined status code");

  a_refused_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> released_now_o == '0)
    else $error("refused item released slots");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken during update");

endmodule

bind sliding_window_ack_tracker_core swat_checker u_swat_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .released_now_o (released_now_o)
);

`default_nettype wire
